[sv/fst_pkg.sv]
`timescale 1ns / 1ps
package fst_pkg;
   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

   localparam logic [2:0] CMD_FIND_CREATE = 3'd0;
   localparam logic [2:0] CMD_COUNT       = 3'd1;
   localparam logic [2:0] CMD_CLOSE       = 3'd2;
   localparam logic [2:0] CMD_SWEEP       = 3'd3;
   localparam logic [2:0] CMD_CLEAR       = 3'd4;

   localparam logic [2:0] ST_HIT       = 3'd0;
   localparam logic [2:0] ST_CREATED   = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_DONE      = 3'd4;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [63:0] flow_key;
      logic [15:0] packet_bytes;
      logic        outgoing;
      logic [63:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  slot;
      logic [63:0] bytes_sent_out;
      logic [63:0] bytes_received_out;
      logic [31:0] packets_sent_out;
      logic [31:0] packets_received_out;
      logic [6:0]  evicted_count;
   } rsp_type;
endpackage

[sv/fst_if.sv]
`timescale 1ns / 1ps
interface fst_req_if;
   import fst_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface fst_rsp_if;
   import fst_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface fst_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[sv/flow_session_table_top.sv]
`timescale 1ns / 1ps
// a lookup request is answered after these steps, in order:
// a key scan reading one entry a cycle from the table memory, a re-read of a hit entry
// and an update step. sweep and clear scan the table the same way; unused codes go straight to the response
// a new request is taken in the cycle after the response has been delivered, and none is
// taken before that. the scan rate is set by the single memory read port
// reset clears the valid bits at once and sets the timeout to 30000; no clearing pass
module flow_session_table_top #(
   parameter int TABLE_DEPTH = fst_pkg::TABLE_DEPTH_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   fst_req_if.sink   req,
   fst_rsp_if.source rsp,
   fst_csr_if.sink   csr
);
   import fst_pkg::*;

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_ACT  = 3'd2;
   localparam logic [2:0] S_RESP = 3'd3;
   localparam logic [2:0] S_SWP  = 3'd4;
   localparam logic [2:0] S_WAIT = 3'd5;

   // table memories
   logic [63:0] key_mem  [TABLE_DEPTH];
   logic [63:0] last_mem [TABLE_DEPTH];
   logic [63:0] btx_mem  [TABLE_DEPTH];
   logic [63:0] brx_mem  [TABLE_DEPTH];
   logic [31:0] ptx_mem  [TABLE_DEPTH];
   logic [31:0] prx_mem  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;

   logic [2:0]  state_ff, state_in;
   req_type     item_ff, item_in;
   rsp_type     out_ff, out_in;
   logic [31:0] timeout_ff, timeout_in;
   logic [CW-1:0] idx_ff, idx_in;        // scan address issued
   logic          rd_vld_ff, rd_vld_in;  // read data valid for rd_idx_ff
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic          hit_ff, hit_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic          free_ff, free_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic [CW-1:0] evict_ff, evict_in;

   logic [63:0] rd_key, rd_last, rd_btx, rd_brx;
   logic [31:0] rd_ptx, rd_prx;
   logic          wr_en;
   logic [IW-1:0] wr_idx, rd_addr;
   logic [63:0] wr_key, wr_last, wr_btx, wr_brx;
   logic [31:0] wr_ptx, wr_prx;
   logic [63:0] age;
   logic [63:0] sum_b;
   logic [63:0] add_b;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_RESP);
   assign rsp.data  = out_ff;
   assign csr.ready = 1'b1;
   assign rd_addr   = idx_ff[IW-1:0];

   // registered read port and single write port
   always_ff @(posedge clock) begin
      rd_key  <= key_mem[rd_addr];
      rd_last <= last_mem[rd_addr];
      rd_btx  <= btx_mem[rd_addr];
      rd_brx  <= brx_mem[rd_addr];
      rd_ptx  <= ptx_mem[rd_addr];
      rd_prx  <= prx_mem[rd_addr];
      if (wr_en) begin
         key_mem[wr_idx]  <= wr_key;
         last_mem[wr_idx] <= wr_last;
         btx_mem[wr_idx]  <= wr_btx;
         brx_mem[wr_idx]  <= wr_brx;
         ptx_mem[wr_idx]  <= wr_ptx;
         prx_mem[wr_idx]  <= wr_prx;
      end
   end

   // subtract unit for ageing, one adder shared by the sent and received byte counts
   assign age   = item_ff.now_ms - rd_last;
   assign add_b = {48'd0, item_ff.packet_bytes};
   assign sum_b = (item_ff.outgoing ? rd_btx : rd_brx) + add_b;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      out_in      = out_ff;
      timeout_in  = timeout_ff;
      valid_in    = valid_ff;
      idx_in      = idx_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      evict_in    = evict_ff;
      wr_en  = 1'b0;
      wr_idx = hit_idx_ff;
      wr_key = rd_key;
      wr_last = item_ff.now_ms;
      wr_btx = rd_btx;
      wr_brx = rd_brx;
      wr_ptx = rd_ptx;
      wr_prx = rd_prx;
      if (csr.valid) begin
         timeout_in = csr.data;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               item_in  = req.data;
               idx_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               evict_in = '0;
               out_in   = '0;
               out_in.status = ST_NOT_FOUND;
               if (req.data.cmd == CMD_SWEEP || req.data.cmd == CMD_CLEAR) begin
                  state_in = S_SWP;
               end else if (req.data.cmd == CMD_FIND_CREATE || req.data.cmd == CMD_COUNT
                            || req.data.cmd == CMD_CLOSE) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         // one entry a cycle: valid bits are flops, key compare on read data
         S_SCAN: begin
            if (idx_ff < CW'(TABLE_DEPTH)) begin
               if (valid_ff[rd_addr] && !hit_ff) begin
                  rd_vld_in = 1'b1;
                  rd_idx_in = rd_addr;
               end
               if (!valid_ff[rd_addr] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_addr;
               end
               idx_in = idx_ff + 1'b1;
            end
            if (rd_vld_ff && !hit_ff && rd_key == item_ff.flow_key) begin
               hit_in     = 1'b1;
               hit_idx_in = rd_idx_ff;
               idx_in     = CW'(rd_idx_ff);
               rd_vld_in  = 1'b0;
               state_in   = S_WAIT;
            end else if (idx_ff >= CW'(TABLE_DEPTH) && !rd_vld_ff) begin
               idx_in   = '0;
               state_in = S_ACT;
            end
         end
         // hit entry address held while the memory reads it again
         S_WAIT: begin
            state_in = S_ACT;
         end
         // on a hit the memory now presents the hit entry (its address was re-issued)
         S_ACT: begin
            state_in = S_RESP;
            if (hit_ff) begin
               out_in.status = ST_HIT;
               out_in.slot   = 6'(hit_idx_ff);
               out_in.bytes_sent_out       = rd_btx;
               out_in.bytes_received_out   = rd_brx;
               out_in.packets_sent_out     = rd_ptx;
               out_in.packets_received_out = rd_prx;
               if (item_ff.cmd == CMD_COUNT) begin
                  wr_en = 1'b1;
                  if (item_ff.outgoing) begin
                     wr_btx = sum_b;
                     wr_ptx = rd_ptx + 32'd1;
                  end else begin
                     wr_brx = sum_b;
                     wr_prx = rd_prx + 32'd1;
                  end
                  out_in.bytes_sent_out       = wr_btx;
                  out_in.bytes_received_out   = wr_brx;
                  out_in.packets_sent_out     = wr_ptx;
                  out_in.packets_received_out = wr_prx;
               end else if (item_ff.cmd == CMD_CLOSE) begin
                  valid_in[hit_idx_ff] = 1'b0;
               end
            end else if (item_ff.cmd == CMD_FIND_CREATE) begin
               if (free_ff) begin
                  wr_en  = 1'b1;
                  wr_idx = free_idx_ff;
                  wr_key = item_ff.flow_key;
                  wr_btx = '0;
                  wr_brx = '0;
                  wr_ptx = '0;
                  wr_prx = '0;
                  valid_in[free_idx_ff] = 1'b1;
                  out_in.status = ST_CREATED;
                  out_in.slot   = 6'(free_idx_ff);
               end else begin
                  out_in.status = ST_FULL;
               end
            end
         end
         // sweep or clear, one entry a cycle; sweep compares through the age subtractor
         S_SWP: begin
            if (idx_ff < CW'(TABLE_DEPTH)) begin
               rd_vld_in = valid_ff[rd_addr];
               rd_idx_in = rd_addr;
               idx_in    = idx_ff + 1'b1;
            end
            if (rd_vld_ff && (item_ff.cmd == CMD_CLEAR || age > {32'd0, timeout_ff})) begin
               valid_in[rd_idx_ff] = 1'b0;
               evict_in = evict_ff + 1'b1;
            end
            if (idx_ff >= CW'(TABLE_DEPTH) && !rd_vld_ff) begin
               out_in.status        = ST_DONE;
               out_in.evicted_count = 7'(evict_ff);
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         timeout_ff <= TIMEOUT_RESET;
         rd_vld_ff  <= 1'b0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
         idx_ff     <= '0;
         evict_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         timeout_ff <= timeout_in;
         rd_vld_ff  <= rd_vld_in;
         hit_ff     <= hit_in;
         free_ff    <= free_in;
         idx_ff     <= idx_in;
         evict_ff   <= evict_in;
      end
      item_ff     <= item_in;
      out_ff      <= out_in;
      rd_idx_ff   <= rd_idx_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
   end
endmodule

[sv/fst_checker.sv]
`timescale 1ns / 1ps
module fst_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [6:0] rsp_evicted
);
   import fst_pkg::*;

   // no request taken while a response is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while response pending");

   // a response stays until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");

   // a taken request drops ready in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready while busy");

   // evicted count only reported with done status
   a_evc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_evicted == 7'd0)
      else $error("eviction count on lookup");
endmodule

bind flow_session_table_top fst_checker u_fst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_status (rsp.data.status),
   .rsp_evicted(rsp.data.evicted_count)
);
